// File: rtl/core/rcpg_pkg.sv
`timescale 1ns / 1ps

package rcpg_pkg;

  localparam int unsigned PixCntW   = 7;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned PhaseW    = 11;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [PixCntW-1:0] MaxPixels   = 7'd64;
  localparam logic [PhaseW-1:0]  PhaseLimit  = 11'd1280;
  localparam logic [7:0]         SegA        = 8'd85;
  localparam logic [7:0]         SegB        = 8'd170;

  // register indexes
  localparam logic [0:0] RegPixelCount   = 1'b0;
  localparam logic [0:0] RegFrameInterval = 1'b1;

  typedef struct packed {
    logic [PixCntW-1:0]   pixel_count;
    logic [IntervalW-1:0] frame_interval;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t wheel_colour(input logic [7:0] pos);
    logic [7:0] q;
    logic [7:0] s;
    logic [9:0] s3;
    logic [7:0] up;
    rgb_t       c;
    q = ~pos;
    if (q < SegA) begin
      s = q;
    end else if (q < SegB) begin
      s = q - SegA;
    end else begin
      s = q - SegB;
    end
    s3 = {2'b00, s} + {1'b0, s, 1'b0};
    up = s3[7:0];
    if (q < SegA) begin
      c.red   = 8'd255 - up;
      c.green = 8'd0;
      c.blue  = up;
    end else if (q < SegB) begin
      c.red   = 8'd0;
      c.green = up;
      c.blue  = 8'd255 - up;
    end else begin
      c.red   = up;
      c.green = 8'd255 - up;
      c.blue  = 8'd0;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/rainbow_cycle_pixel_generator.sv
`timescale 1ns / 1ps

// Rainbow-cycle pixel generator.
// Input channel: one time stamp beat per tick (in_valid_i / in_stall_o).
// Output channel: one beat per pixel (out_valid_o / out_stall_i) carrying the
// pixel index, its RGB colour and frame_end on the last pixel of a frame.
// Configuration: APB registers pixel_count (addr 0) and frame_interval (addr 4).
// Each tick first runs the restoring divider to test alignment of the
// stamp to frame_interval. An aligned tick with phase below 1280 then reuses
// the same divider for 256 / pixel_count, after which pixels come out one
// per cycle while the output is not stalled; with a pixel count of 0 only
// the phase advances. An aligned tick at phase 1280 resets the phase to 0.
// in_stall_o is high from acceptance until the last pixel is loaded into the
// output register, or until the alignment test ends when no frame follows.
// A stalled output beat holds and pixel generation waits.
// Reset clears the phase, empties the output register and restores
// pixel_count to 64 and frame_interval to 1.
module rainbow_cycle_pixel_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcpg_pkg::AddrW-1:0]       paddr,
  input  logic [rcpg_pkg::DataW-1:0]       pwdata,
  output logic [rcpg_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rcpg_pkg::TimeW-1:0]       time_now_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [5:0]                       pixel_index_o,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o,
  output logic                             frame_end_o
);
  import rcpg_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMod  = 2'd1;
  localparam logic [1:0] SDiv  = 2'd2;
  localparam logic [1:0] SEmit = 2'd3;

  cfg_t                 cfg;
  logic [1:0]           state_q, state_d;
  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [PixCntW-1:0]   idx_q, idx_d;
  logic [8:0]           step_q, step_d;
  logic [PixCntW-1:0]   rstep_q, rstep_d;
  logic [8:0]           acc_q, acc_d;
  logic [PixCntW-1:0]   accr_q, accr_d;

  logic                 out_valid_q, out_valid_d;
  logic [5:0]           pix_q;
  rgb_t                 rgb_q;
  logic                 fend_q;

  logic                 div_start;
  logic [TimeW-1:0]     div_dividend;
  logic [IntervalW-1:0] div_divisor;
  logic                 div_done;
  logic [TimeW-1:0]     div_quo;
  logic [IntervalW-1:0] div_rem;

  logic [PixCntW-1:0]   n_eff;
  logic                 in_acc;
  logic                 aligned;
  logic                 out_free;
  logic                 load;
  logic                 last;
  logic [7:0]           pos;
  rgb_t                 colour;
  logic [PixCntW:0]     rsum;
  logic                 wrap;

  rcpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcpg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign n_eff    = (cfg.pixel_count > MaxPixels) ? MaxPixels : cfg.pixel_count;
  assign in_stall_o = (state_q != SIdle);
  assign in_acc   = in_valid_i & (state_q == SIdle);
  assign aligned  = (cfg.frame_interval == '0) || (div_rem == '0);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign load     = (state_q == SEmit) & out_free;
  assign last     = (idx_q == n_eff - 7'd1);
  assign pos      = acc_q[7:0] + phase_q[7:0];
  assign colour   = wheel_colour(pos);
  assign rsum     = {1'b0, accr_q} + {1'b0, rstep_q};
  assign wrap     = (rsum >= {1'b0, n_eff});

  assign div_dividend = (state_q == SIdle) ? time_now_i : 32'd256;
  assign div_divisor  = (state_q == SIdle) ? cfg.frame_interval
                                           : {{(IntervalW-PixCntW){1'b0}}, n_eff};

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    step_d      = step_q;
    rstep_d     = rstep_q;
    acc_d       = acc_q;
    accr_d      = accr_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          div_start = 1'b1;
          state_d   = SMod;
        end
      end
      SMod: begin
        if (div_done) begin
          state_d = SIdle;
          if (aligned) begin
            if (phase_q < PhaseLimit) begin
              if (n_eff == '0) begin
                phase_d = phase_q + 11'd1;
              end else begin
                div_start = 1'b1;
                state_d   = SDiv;
              end
            end else if (phase_q == PhaseLimit) begin
              phase_d = '0;
            end
          end
        end
      end
      SDiv: begin
        if (div_done) begin
          step_d  = div_quo[8:0];
          rstep_d = div_rem[PixCntW-1:0];
          acc_d   = '0;
          accr_d  = '0;
          idx_d   = '0;
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (load) begin
          out_valid_d = 1'b1;
          idx_d       = idx_q + 7'd1;
          // advance position by 256/n, carrying the fractional remainder
          if (wrap) begin
            accr_d = rsum[PixCntW-1:0] - n_eff;
            acc_d  = acc_q + step_q + 9'd1;
          end else begin
            accr_d = rsum[PixCntW-1:0];
            acc_d  = acc_q + step_q;
          end
          if (last) begin
            phase_d = phase_q + 11'd1;
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    step_q  <= step_d;
    rstep_q <= rstep_d;
    acc_q   <= acc_d;
    accr_q  <= accr_d;
    if (load) begin
      pix_q  <= idx_q[5:0];
      rgb_q  <= colour;
      fend_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pix_q;
  assign red_o         = rgb_q.red;
  assign green_o       = rgb_q.green;
  assign blue_o        = rgb_q.blue;
  assign frame_end_o   = fend_q;

endmodule

// File: rtl/core/rcpg_regs.sv
`timescale 1ns / 1ps

module rcpg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcpg_pkg::AddrW-1:0]     paddr,
  input  logic [rcpg_pkg::DataW-1:0]     pwdata,
  output logic [rcpg_pkg::DataW-1:0]     prdata,
  output logic                           pready,
  output rcpg_pkg::cfg_t                 cfg_o
);
  import rcpg_pkg::*;

  logic [PixCntW-1:0]   pixel_count_q;
  logic [IntervalW-1:0] frame_interval_q;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q    <= MaxPixels;
      frame_interval_q <= 16'd1;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegPixelCount:    pixel_count_q    <= pwdata[PixCntW-1:0];
        RegFrameInterval: frame_interval_q <= pwdata[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegPixelCount:    prdata = {{(DataW-PixCntW){1'b0}}, pixel_count_q};
      RegFrameInterval: prdata = {{(DataW-IntervalW){1'b0}}, frame_interval_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.pixel_count    = pixel_count_q;
  assign cfg_o.frame_interval = frame_interval_q;

endmodule

// File: rtl/core/rcpg_div.sv
`timescale 1ns / 1ps

module rcpg_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rcpg_pkg::TimeW-1:0]       dividend_i,
  input  logic [rcpg_pkg::IntervalW-1:0]   divisor_i,
  output logic                             done_o,
  output logic [rcpg_pkg::TimeW-1:0]       quotient_o,
  output logic [rcpg_pkg::IntervalW-1:0]   remainder_o
);
  import rcpg_pkg::*;

  logic                   busy_q;
  logic [4:0]             cnt_q;
  logic                   done_q;
  logic [TimeW-1:0]       quo_q;
  logic [IntervalW-1:0]   rem_q;
  logic [IntervalW-1:0]   dsr_q;
  logic [IntervalW:0]     trial;
  logic [IntervalW:0]     diff;
  logic                   fits;

  // one restoring step per cycle, MSB first
  assign trial = {rem_q, quo_q[TimeW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TimeW-2:0], fits};
      rem_q <= fits ? diff[IntervalW-1:0] : trial[IntervalW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import rcpg_pkg::*;

  localparam int unsigned SettleCycles = 150;
  localparam int unsigned QuietLimit   = 4000;

  typedef struct packed {
    logic [5:0] pix_idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  class frame_scoreboard;
    logic [PixCntW-1:0]   pixel_count;
    logic [IntervalW-1:0] frame_interval;
    logic [PhaseW-1:0]    phase;
    pixel_t               pixels_due[$];
    int unsigned          errors;

    function new();
      pixel_count    = MaxPixels;
      frame_interval = 16'd1;
      phase          = '0;
      errors         = 0;
    endfunction

    // wheel position -> colour; the frame_end flag is filled in by the caller
    function pixel_t shade(int unsigned slot, int unsigned at);
      pixel_t      p;
      int unsigned q;
      q = 255 - (at & 255);
      p.pix_idx   = slot[5:0];
      p.frame_end = 1'b0;
      if (q < SegA) begin
        p.red   = 8'(255 - 3 * q);
        p.green = 8'd0;
        p.blue  = 8'(3 * q);
      end else if (q < SegB) begin
        q = q - SegA;
        p.red   = 8'd0;
        p.green = 8'(3 * q);
        p.blue  = 8'(255 - 3 * q);
      end else begin
        q = q - SegB;
        p.red   = 8'(3 * q);
        p.green = 8'(255 - 3 * q);
        p.blue  = 8'd0;
      end
      return p;
    endfunction

    function void note_stamp(logic [TimeW-1:0] stamp);
      int unsigned n;
      pixel_t      p;
      if (frame_interval != 0 && (stamp % frame_interval) != 0) return;
      if (phase < PhaseLimit) begin
        n = (pixel_count > MaxPixels) ? MaxPixels : pixel_count;
        for (int unsigned i = 0; i < n; i++) begin
          p = shade(i, (i * 256 / n + phase) & 255);
          p.frame_end = (i + 1 == n);
          pixels_due.push_back(p);
        end
        phase = phase + 1'b1;
      end else if (phase == PhaseLimit) begin
        phase = '0;
      end
    endfunction

    function void match(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        $error("pixel beat with nothing due: pixel_index %0d", got.pix_idx);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      match("pixel_index", want.pix_idx, got.pix_idx);
      match("red", want.red, got.red);
      match("green", want.green, got.green);
      match("blue", want.blue, got.blue);
      match("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [TimeW-1:0]     time_now_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [5:0]           pixel_index_o;
  logic [7:0]           red_o;
  logic [7:0]           green_o;
  logic [7:0]           blue_o;
  logic                 frame_end_o;

  frame_scoreboard board;
  bit              calm;
  int unsigned     stall_left = 0;
  int unsigned     quiet;

  rainbow_cycle_pixel_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .time_now_i    (time_now_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver stalls in random bursts, none started while calm
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 17);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : monitor
    pixel_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_stamp(time_now_i);
      if (out_valid_o && !out_stall_i) begin
        seen.pix_idx   = pixel_index_o;
        seen.red       = red_o;
        seen.green     = green_o;
        seen.blue      = blue_o;
        seen.frame_end = frame_end_o;
        board.check_pixel(seen);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_stamp(input logic [TimeW-1:0] stamp);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_now_i <= stamp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid, wait for every due pixel, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pixels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] reg_idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == RegPixelCount) begin
      board.pixel_count = value[PixCntW-1:0];
    end else begin
      board.frame_interval = value[IntervalW-1:0];
    end
  endtask

  task automatic configure(input logic [PixCntW-1:0] count, input logic [IntervalW-1:0] every);
    drain();
    write_reg(RegPixelCount, count);
    write_reg(RegFrameInterval, every);
  endtask

  // mostly stamps on the frame grid, the rest anywhere
  function automatic logic [TimeW-1:0] pick_stamp(input logic [IntervalW-1:0] every);
    if (every == 0 || $urandom_range(0, 3) == 0) return $urandom();
    return every * $urandom_range(0, 32'hFFFF_FFFF / every);
  endfunction

  initial begin
    logic [PixCntW-1:0]   count;
    logic [IntervalW-1:0] every;
    board       = new();
    calm        = 1'b0;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    time_now_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 64 pixels, every stamp aligned
    push_stamp('0);
    push_stamp('1);
    push_stamp(32'h8000_0001);
    // zero interval treats every stamp as aligned
    configure(1, 0);
    push_stamp(32'h5555_AAAA);
    push_stamp(3);
    // zero pixels: no beats, phase still advances
    configure(0, 16'hFFFF);
    push_stamp(32'd196605);
    push_stamp(32'd65534);
    push_stamp('0);
    // oversized pixel count saturates
    configure(7'h7F, 16'hFFFF);
    push_stamp('1);
    push_stamp(32'd131071);
    configure(65, 2);
    push_stamp(2);
    push_stamp(5);
    push_stamp(32'hFFFF_FFFE);
    configure(3, 7);
    push_stamp(14);
    push_stamp(15);
    push_stamp(21);

    for (int seg = 0; seg < 6; seg++) begin
      calm = (seg == 2 || seg == 5);
      case ($urandom_range(0, 5))
        0:       count = '0;
        1:       count = 7'd1;
        2:       count = MaxPixels;
        3:       count = 7'h7F;
        4:       count = 7'($urandom_range(65, 126));
        default: count = 7'($urandom_range(2, 63));
      endcase
      case ($urandom_range(0, 4))
        0:       every = '0;
        1:       every = 16'd1;
        2:       every = 16'hFFFF;
        3:       every = 16'($urandom_range(2, 16));
        default: every = 16'($urandom_range(17, 65534));
      endcase
      configure(count, every);
      repeat (17) push_stamp(pick_stamp(every));
    end

    drain();
    if (board.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rcpg_pkg.sv
rtl/core/rcpg_regs.sv
rtl/core/rcpg_div.sv
rtl/core/rainbow_cycle_pixel_generator.sv
tb/tb.sv
